// ===== src/att_pkg.sv =====
// Package for the triple-tap detector: payload structs, register indexes, constants.
// No dependencies.
package att_pkg;

  typedef struct packed {
    logic signed [15:0] x_raw;
    logic signed [15:0] y_raw;
    logic signed [15:0] z_raw;
    logic [31:0]        sample_time;
  } in_beat_t;

  typedef struct packed {
    logic        reading_ok;
    logic        tap_taken;
    logic        triple_tap;
    logic        vibration_reject;
    logic [2:0]  axis_hits;
    logic [16:0] magnitude_out;
    logic [16:0] baseline_out;
    logic [3:0]  taps_pending;
    logic        armed_out;
    logic [31:0] reject_total;
  } out_beat_t;

  localparam logic [2:0] REG_OFS_X = 3'd0;
  localparam logic [2:0] REG_OFS_Y = 3'd1;
  localparam logic [2:0] REG_OFS_Z = 3'd2;
  localparam logic [2:0] REG_THR   = 3'd3;
  localparam logic [2:0] REG_WIN   = 3'd4;
  localparam logic [2:0] REG_GAP   = 3'd5;
  localparam logic [2:0] REG_LOCK  = 3'd6;
  localparam logic [2:0] REG_ALPHA = 3'd7;

  localparam int unsigned TAPS_NEEDED = 3;
  localparam logic [29:0] ONE_G_FINE  = 30'd1 << 25;
  localparam logic [29:0] HALF_G_FINE = 30'd1 << 24;

  // square root operand: sum of three 17-bit squares fits in 36 bits
  localparam int unsigned SQ_W = 36;

  // ceil(2^44 / 100): x * DIV100_RECIP >> 44 equals x / 100 for any 37-bit x
  localparam logic [37:0] DIV100_RECIP = 38'd175921860445;

endpackage

// ===== src/att_sqrt.sv =====
// Bit-serial integer square root, one result bit per cycle.
// Depends on att_pkg.
module att_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [att_pkg::SQ_W-1:0]   radicand,
  output logic                       done,
  output logic [17:0]                root
);
  import att_pkg::*;

  logic [SQ_W-1:0] rem_r, rem_nxt;
  logic [SQ_W-1:0] res_r, res_nxt;
  logic [SQ_W-1:0] bit_r, bit_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;

  always_comb begin
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = radicand;
      res_nxt  = '0;
      bit_nxt  = {2'b01, {(SQ_W-2){1'b0}}};
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= res_r + bit_r) begin
        rem_nxt = rem_r - (res_r + bit_r);
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0] || bit_r[1]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign done = done_r;
  assign root = res_r[17:0];
endmodule

// ===== src/att_div100.sv =====
// Divide by 100 through a reciprocal multiply, 13 dividend bits per cycle.
// Depends on att_pkg (reciprocal constant).
module att_div100 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [36:0] dividend,
  output logic        done,
  output logic [29:0] quotient
);
  import att_pkg::*;

  logic [36:0] n_r, n_nxt;
  logic [51:0] acc_r, acc_nxt;
  logic [1:0]  step_r, step_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [51:0] part;

  // low 13-bit chunk of the dividend times the reciprocal
  assign part = 52'(n_r[12:0]) * 52'(DIV100_RECIP);

  // acc keeps x * recip >> (13 * steps); the bits shifted out never reach the floor
  always_comb begin
    n_nxt    = n_r;
    acc_nxt  = acc_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      n_nxt    = dividend;
      acc_nxt  = '0;
      step_nxt = 2'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt  = (acc_r >> 13) + part;
      n_nxt    = n_r >> 13;
      step_nxt = step_r + 2'd1;
      if (step_r == 2'd2) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    n_r    <= n_nxt;
    acc_r  <= acc_nxt;
    step_r <= step_nxt;
  end

  // remaining shift: 44 - 2 * 13
  assign done     = done_r;
  assign quotient = acc_r[47:18];
endmodule

// ===== src/accel_triple_tap_detector_core.sv =====
// Triple-tap detector top level: config registers, sequencer, shared multiplier.
// Depends on att_pkg, att_sqrt, att_div100.
// Path per sample: squares, 18-step root, range check; a first or out-of-range sample
//   then goes out, others pass the filter and tap logic (3-step divide by 100 for the
//   baseline update). One sample at a time: in_stall is high from accept until the result
//   moves to the output register. Sync active-low reset: default regs, 1.0 g levels, no taps.
module accel_triple_tap_detector_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  att_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output att_pkg::out_beat_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [16:0]        cfg_data
);
  import att_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_SQRT, S_CHECK, S_MUL1, S_MUL2, S_FILT,
    S_DIV, S_TAP, S_OUT
  } state_t;

  // config registers
  logic signed [13:0] ofs_x_r, ofs_y_r, ofs_z_r;
  logic [14:0] thr_r;
  logic [10:0] win_r;
  logic [15:0] gap_r, lock_r;
  logic [16:0] alpha_r;

  // tracked state
  logic        seeded_r, armed_r, tap_seen_r, det_seen_r;
  logic [29:0] base_r, filt_r;
  logic [3:0]  cnt_r;
  logic [31:0] wstart_r, last_tap_r, last_det_r, rej_r;

  // per-sample working registers
  state_t      state_r;
  logic [1:0]  axis_r;
  logic [16:0] ax_r, ay_r, az_r;
  logic [31:0] now_r;
  logic [SQ_W-1:0] sum_r;
  logic [16:0] mag_r;
  logic        stable_r;
  logic [47:0] acc_r;
  out_beat_t   res_r;        // result under construction
  out_beat_t   out_r;        // result beat on the output channel
  logic        out_valid_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ofs_x_r <= '0; ofs_y_r <= '0; ofs_z_r <= '0;
      thr_r <= 15'd6144; win_r <= 11'd1000; gap_r <= 16'd50;
      lock_r <= 16'd1000; alpha_r <= 17'd6554;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OFS_X: ofs_x_r <= cfg_data[13:0];
        REG_OFS_Y: ofs_y_r <= cfg_data[13:0];
        REG_OFS_Z: ofs_z_r <= cfg_data[13:0];
        REG_THR: begin
          if (cfg_data[14:0] < 15'd2048) thr_r <= 15'd2048;
          else if (cfg_data[14:0] > 15'd20480) thr_r <= 15'd20480;
          else thr_r <= cfg_data[14:0];
        end
        REG_WIN: begin
          if (cfg_data[10:0] < 11'd100) win_r <= 11'd100;
          else if (cfg_data[10:0] > 11'd2000) win_r <= 11'd2000;
          else win_r <= cfg_data[10:0];
        end
        REG_GAP:  gap_r <= cfg_data[15:0];
        REG_LOCK: lock_r <= cfg_data[15:0];
        REG_ALPHA: alpha_r <= (cfg_data > 17'd65536) ? 17'd65536 : cfg_data;
        default: ;
      endcase
    end
  end

  // offset-corrected axis values, signed
  logic signed [17:0] cx, cy, cz;
  assign cx = 18'(in_data.x_raw) - 18'(ofs_x_r);
  assign cy = 18'(in_data.y_raw) - 18'(ofs_y_r);
  assign cz = 18'(in_data.z_raw) - 18'(ofs_z_r);

  // shared 17x17 squarer / 17x30 multiplier
  logic [16:0] mul_a;
  logic [29:0] mul_b;
  logic [46:0] mul_p;
  always_comb begin
    mul_a = ax_r;
    mul_b = {13'd0, ax_r};
    case (state_r)
      S_SQ: begin
        case (axis_r)
          2'd0: begin mul_a = ax_r; mul_b = {13'd0, ax_r}; end
          2'd1: begin mul_a = ay_r; mul_b = {13'd0, ay_r}; end
          default: begin mul_a = az_r; mul_b = {13'd0, az_r}; end
        endcase
      end
      S_MUL1: begin mul_a = alpha_r; mul_b = {mag_r, 13'd0}; end
      S_MUL2: begin mul_a = 17'(17'd65536 - alpha_r); mul_b = filt_r; end
      default: ;
    endcase
  end
  assign mul_p = 47'(mul_a) * 47'(mul_b);

  logic sq_start, sq_done;
  logic [17:0] sq_root;
  att_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sum_r),
    .done(sq_done), .root(sq_root)
  );

  logic dv_start, dv_done;
  logic [29:0] dv_q;
  logic [36:0] dv_in;
  assign dv_in = 37'(base_r) * 37'd99 + 37'(filt_r) + 37'd50;
  att_div100 u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_in),
    .done(dv_done), .quotient(dv_q)
  );

  assign sq_start = (state_r == S_SQRT) && (axis_r == 2'd3);
  assign dv_start = (state_r == S_DIV) && (axis_r == 2'd0);

  logic [29:0] magf;
  assign magf = {mag_r, 13'd0};
  logic [29:0] dmag;
  assign dmag = (magf >= base_r) ? magf - base_r : base_r - magf;
  logic [16:0] mag_sat;
  assign mag_sat = sq_root[17] ? 17'h1FFFF : sq_root[16:0];

  logic [31:0] dt_tap, dt_det, dt_win;
  assign dt_tap = now_r - last_tap_r;
  assign dt_det = now_r - last_det_r;
  assign dt_win = now_r - wstart_r;

  logic [3:0] cnt_inc;
  assign cnt_inc = cnt_r + 4'd1;

  // finished result plus the state fields as they stand after the sample
  out_beat_t res_full;
  always_comb begin
    res_full = res_r;
    res_full.baseline_out = base_r[29:13];
    res_full.taps_pending = cnt_r;
    res_full.armed_out = armed_r;
    res_full.reject_total = rej_r;
  end

  // hand-off into the output register once the previous beat has left
  logic load_out;
  assign load_out = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      seeded_r <= 1'b0; armed_r <= 1'b0; tap_seen_r <= 1'b0; det_seen_r <= 1'b0;
      base_r <= ONE_G_FINE; filt_r <= ONE_G_FINE;
      cnt_r <= '0; wstart_r <= '0; last_tap_r <= '0; last_det_r <= '0; rej_r <= '0;
      axis_r <= '0;
    end else begin
      out_valid_r <= load_out || (out_valid_r && out_stall);
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            ax_r <= cx[17] ? 17'(-cx) : cx[16:0];
            ay_r <= cy[17] ? 17'(-cy) : cy[16:0];
            az_r <= cz[17] ? 17'(-cz) : cz[16:0];
            now_r <= in_data.sample_time;
            sum_r <= '0;
            axis_r <= 2'd0;
            res_r <= '0;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          sum_r <= sum_r + SQ_W'(mul_p[33:0]);
          if (axis_r == 2'd2) begin
            axis_r <= 2'd3;
            state_r <= S_SQRT;
          end else axis_r <= axis_r + 2'd1;
          res_r.axis_hits[axis_r] <= (mul_a >= 17'(thr_r));
        end
        S_SQRT: begin
          axis_r <= 2'd0;
          if (sq_done) begin
            mag_r <= mag_sat;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_r.reading_ok <= !(21'(mag_r) * 21'd10 < 21'd4096) && !(mag_r > 17'd81920);
          res_r.magnitude_out <= mag_r;
          stable_r <= dmag < HALF_G_FINE;
          if (!seeded_r) begin
            seeded_r <= 1'b1;
            base_r <= magf;
            filt_r <= magf;
            state_r <= S_OUT;
          end else if (!(!(21'(mag_r) * 21'd10 < 21'd4096) && !(mag_r > 17'd81920))) begin
            state_r <= S_OUT;
          end else state_r <= S_MUL1;
        end
        S_MUL1: begin
          acc_r <= 48'(mul_p) + 48'd32768;
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          acc_r <= acc_r + 48'(mul_p);
          state_r <= S_FILT;
        end
        S_FILT: begin
          filt_r <= acc_r[45:16];
          axis_r <= 2'd0;
          state_r <= stable_r ? S_DIV : S_TAP;
        end
        S_DIV: begin
          axis_r <= 2'd1;
          if (dv_done) begin
            base_r <= dv_q;
            state_r <= S_TAP;
          end
        end
        S_TAP: begin
          state_r <= S_OUT;
          if (dmag >= {thr_r, 13'd0}) begin
            if (tap_seen_r && dt_tap < 32'(gap_r)) begin
              res_r.vibration_reject <= 1'b1;
              rej_r <= rej_r + 32'd1;
            end else if (!armed_r && det_seen_r && dt_det < 32'(lock_r)) begin
              // locked out after a detection
            end else begin
              res_r.tap_taken <= 1'b1;
              last_tap_r <= now_r;
              tap_seen_r <= 1'b1;
              if (cnt_r == 4'd0) armed_r <= 1'b1;
              if (cnt_inc >= 4'(TAPS_NEEDED)) begin
                if (cnt_r != 4'd0 && dt_win > 32'(win_r)) begin
                  cnt_r <= 4'd1;
                  wstart_r <= now_r;
                end else begin
                  res_r.triple_tap <= 1'b1;
                  last_det_r <= now_r;
                  det_seen_r <= 1'b1;
                  armed_r <= 1'b0;
                  cnt_r <= 4'd0;
                end
              end else begin
                cnt_r <= cnt_inc;
                if (cnt_r == 4'd0) wstart_r <= now_r;
              end
            end
          end
        end
        S_OUT: begin
          if (load_out) begin
            out_r <= res_full;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule

// ===== tb/accel_triple_tap_detector_core_test.sv =====
// Testbench for accel_triple_tap_detector_core: directed and random sample streams,
// checked beat by beat against a cycle-free predictor. Depends on att_pkg and the core.
`timescale 1ns / 1ps

module accel_triple_tap_detector_core_test;
  import att_pkg::*;

  localparam int IDLE_LIMIT = 5000;   // cycles with no beat on any channel
  localparam int LONG_HOLD  = 400;    // receiver hold-off for the fill-up test

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [2:0]  cfg_index;
  logic [16:0] cfg_data;

  accel_triple_tap_detector_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: register copies and detector state, fine units 2^-25 g
  // ---------------------------------------------------------------------------
  int          ofs_x, ofs_y, ofs_z;
  int unsigned thr_lsb, win_ms, gap_ms, lock_ms, alpha_q16;

  bit              seeded;
  longint unsigned base_fine, filt_fine;
  int unsigned     tap_cnt;
  bit              armed, tap_seen, det_seen;
  logic [31:0]     win_start, last_tap, last_det, rej_cnt;

  out_beat_t   expected_q[$];
  int          n_items, n_results, n_fail, n_triples, n_vib, n_taps;
  logic [31:0] now_ms;      // stimulus timestamp
  int          burst_left;
  bit          gaps_on;
  int          hold_ask;    // bumped by the test flow; receiver serves it

  function automatic longint unsigned fsqrt(longint unsigned n);
    longint unsigned r, t;
    r = 0;
    for (int b = 18; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic longint unsigned adiff(longint unsigned a, longint unsigned b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Register write as the block sees it: clamps apply at write time.
  function automatic void apply_reg(logic [2:0] idx, logic [16:0] v);
    case (idx)
      REG_OFS_X: ofs_x = int'($signed(v[13:0]));
      REG_OFS_Y: ofs_y = int'($signed(v[13:0]));
      REG_OFS_Z: ofs_z = int'($signed(v[13:0]));
      REG_THR: begin
        thr_lsb = v[14:0];
        if (thr_lsb < 2048) thr_lsb = 2048;
        if (thr_lsb > 20480) thr_lsb = 20480;
      end
      REG_WIN: begin
        win_ms = v[10:0];
        if (win_ms < 100) win_ms = 100;
        if (win_ms > 2000) win_ms = 2000;
      end
      REG_GAP:  gap_ms = v[15:0];
      REG_LOCK: lock_ms = v[15:0];
      REG_ALPHA: alpha_q16 = (v > 17'd65536) ? 65536 : v;
      default: ;
    endcase
  endfunction

  function automatic out_beat_t predict_sample(in_beat_t b);
    longint          cx, cy, cz;
    longint unsigned ax, ay, az, mag, magf;
    logic [31:0]     now;
    bit              stable;
    out_beat_t       r;
    cx = longint'($signed(b.x_raw)) - ofs_x;
    cy = longint'($signed(b.y_raw)) - ofs_y;
    cz = longint'($signed(b.z_raw)) - ofs_z;
    ax = (cx < 0) ? -cx : cx;
    ay = (cy < 0) ? -cy : cy;
    az = (cz < 0) ? -cz : cz;
    now = b.sample_time;
    mag = fsqrt(ax * ax + ay * ay + az * az);
    if (mag > 64'h1FFFF) mag = 64'h1FFFF;
    magf = mag << 13;
    r = '0;
    r.reading_ok = !(mag * 10 < 4096) && !(mag > 81920);
    r.axis_hits = {az >= thr_lsb, ay >= thr_lsb, ax >= thr_lsb};

    if (!seeded) begin
      // first sample seeds both levels, even when out of range
      seeded = 1'b1;
      base_fine = magf;
      filt_fine = magf;
    end else if (r.reading_ok) begin
      stable = adiff(magf, base_fine) < (64'd1 << 24);
      filt_fine = (alpha_q16 * magf + (65536 - alpha_q16) * filt_fine + 32768) >> 16;
      if (stable) base_fine = (base_fine * 99 + filt_fine + 50) / 100;
      if (adiff(magf, base_fine) >= (longint'(thr_lsb) << 13)) begin
        if (tap_seen && (now - last_tap) < gap_ms) begin
          r.vibration_reject = 1'b1;
          rej_cnt = rej_cnt + 1;
        end else if (!armed && det_seen && (now - last_det) < lock_ms) begin
          // lockout after a detection: dropped without a flag
        end else begin
          r.tap_taken = 1'b1;
          last_tap = now;
          tap_seen = 1'b1;
          if (tap_cnt == 0) begin
            win_start = now;
            armed = 1'b1;
          end
          tap_cnt++;
          if (tap_cnt >= TAPS_NEEDED) begin
            if ((now - win_start) <= win_ms) begin
              r.triple_tap = 1'b1;
              last_det = now;
              det_seen = 1'b1;
              armed = 1'b0;
              tap_cnt = 0;
            end else begin
              // window ran out: this tap opens a new sequence
              tap_cnt = 1;
              win_start = now;
            end
          end
        end
      end
    end
    r.magnitude_out = mag[16:0];
    r.baseline_out = base_fine[29:13];
    r.taps_pending = tap_cnt[3:0];
    r.armed_out = armed;
    r.reject_total = rej_cnt;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  task automatic field_chk(string nm, longint unsigned e, longint unsigned a);
    if (e != a) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, nm, e, a);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin
    out_beat_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (out_data.triple_tap) n_triples++;
      if (out_data.vibration_reject) n_vib++;
      if (out_data.tap_taken) n_taps++;
      if (expected_q.size() == 0) begin
        $display("%0t ns: result beat with nothing expected, got %h", $time, out_data);
        n_fail++;
      end else begin
        e = expected_q.pop_front();
        field_chk("reading_ok", e.reading_ok, out_data.reading_ok);
        field_chk("tap_taken", e.tap_taken, out_data.tap_taken);
        field_chk("triple_tap", e.triple_tap, out_data.triple_tap);
        field_chk("vibration_reject", e.vibration_reject, out_data.vibration_reject);
        field_chk("axis_hits", e.axis_hits, out_data.axis_hits);
        field_chk("magnitude_out", e.magnitude_out, out_data.magnitude_out);
        field_chk("baseline_out", e.baseline_out, out_data.baseline_out);
        field_chk("taps_pending", e.taps_pending, out_data.taps_pending);
        field_chk("armed_out", e.armed_out, out_data.armed_out);
        field_chk("reject_total", e.reject_total, out_data.reject_total);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern rotates through four modes; long hold on request
  // ---------------------------------------------------------------------------
  int hold_left, hold_served, stall_tick;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_served <= 0;
      stall_tick <= 0;
    end else begin
      stall_tick <= stall_tick + 1;
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (hold_served != hold_ask) begin
        hold_served <= hold_ask;
        hold_left <= LONG_HOLD;
        out_stall <= 1'b1;
      end else begin
        case ((stall_tick >> 6) % 4)
          0: out_stall <= 1'b0;                          // free flowing
          1: out_stall <= ($urandom_range(0, 99) < 30);
          2: out_stall <= (stall_tick % 7) < 3;
          default: out_stall <= ($urandom_range(0, 99) < 70);
        endcase
      end
    end
  end

  // Watchdog: any beat on any channel restarts the count
  int idle_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ns: timeout, no beat for %0d cycles", $time, IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // ---------------------------------------------------------------------------
  // Sender and register writer
  // ---------------------------------------------------------------------------
  // Valid stays up between beats of a burst; gaps drop it.
  task automatic send_beat(in_beat_t b);
    int gap;
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(predict_sample(b));
    n_items++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = gaps_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic sample_at(int x, int y, int z, int unsigned dt);
    in_beat_t b;
    now_ms = now_ms + dt;
    b.x_raw = x[15:0];
    b.y_raw = y[15:0];
    b.z_raw = z[15:0];
    b.sample_time = now_ms;
    send_beat(b);
  endtask

  task automatic quiet(int unsigned dt);
    sample_at($urandom_range(0, 60) - 30, $urandom_range(0, 60) - 30,
              4096 + $urandom_range(0, 200) - 100, dt);
  endtask

  // spike well past threshold on a random axis
  task automatic tap(int unsigned dt);
    int amp;
    amp = 4096 + thr_lsb + 600 + $urandom_range(0, 3000);
    if (amp > 32767) amp = 32767;
    case ($urandom_range(0, 2))
      0: sample_at(amp, 0, 4096, dt);
      1: sample_at(0, -amp, 4096, dt);
      default: sample_at(0, 0, ($urandom_range(0, 1) ? amp : -amp), dt);
    endcase
  endtask

  // Idle point: lower valid, wait out every result plus the worst latency
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [16:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle_baseline();
    repeat (4) quiet(10);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_first_and_range();
    sample_at(0, 0, 4096, 5);            // seeds baseline at 1 g
    sample_at(0, 0, 0, 5);               // zero magnitude, below 0.1 g
    sample_at(200, 100, 150, 5);         // well under 0.1 g
    sample_at(0, 0, 410, 5);             // just above 0.1 g
    sample_at(32767, 32767, 32767, 5);   // field maxima
    sample_at(-32768, -32768, -32768, 5);
    sample_at(-32768, 32767, 0, 5);
    settle_baseline();
  endtask

  task automatic test_triple_tap();
    tap(200); quiet(20); tap(150); quiet(20); tap(150);
    settle_baseline();
  endtask

  task automatic test_vibration();
    quiet(1500);
    tap(10); tap(10); tap(5);             // inside min gap
    settle_baseline();
  endtask

  task automatic test_lockout();
    quiet(1200);
    tap(10); tap(100); tap(100);          // second tap: window run out, count restarts
    tap(200);                              // detection
    tap(1000);                             // past lockout
    settle_baseline();
  endtask

  task automatic test_window_expired();
    quiet(2000);
    tap(10); tap(600); tap(600);           // second lands past the window
    tap(100); tap(100);
    settle_baseline();
  endtask

  task automatic test_time_wrap();
    drain();
    now_ms = 32'hFFFF_FF00;
    quiet(0); tap(10); tap(120); tap(120); quiet(10);   // last sample is past the wrap
  endtask

  task automatic test_register_extremes();
    drain();
    write_reg(REG_OFS_X, 17'h1E000);      // -8192, junk in upper bits
    write_reg(REG_OFS_Y, 17'h01FFF);      // 8191
    write_reg(REG_OFS_Z, 17'h02000);      // -8192
    write_reg(REG_THR, 17'h00000);        // clamps to 0.5 g
    write_reg(REG_WIN, 17'h007FF);        // clamps to 2000
    write_reg(REG_GAP, 17'h0FFFF);
    write_reg(REG_LOCK, 17'h00000);
    write_reg(REG_ALPHA, 17'h1FFFF);      // clamps to 1.0
    sample_at(-32768, 32767, -32768, 5);
    sample_at(32767, -32768, 32767, 5);
    sample_at(-8192, 8191, -8192 + 4096, 5);
    tap(100); tap(100);
    drain();
    write_reg(REG_OFS_X, 17'd0);
    write_reg(REG_OFS_Y, 17'd0);
    write_reg(REG_OFS_Z, 17'd0);
    write_reg(REG_THR, 17'h07FFF);        // clamps to 5 g
    write_reg(REG_WIN, 17'd0);            // clamps to 100
    write_reg(REG_GAP, 17'd0);
    write_reg(REG_LOCK, 17'h0FFFF);
    write_reg(REG_ALPHA, 17'd0);
    settle_baseline();
    tap(10); tap(30); tap(30); tap(30); tap(200);
    drain();
    write_reg(REG_ALPHA, 17'd65536);
    write_reg(REG_THR, 17'd20480);
    write_reg(REG_WIN, 17'd2000);
    settle_baseline();
  endtask

  task automatic random_config();
    drain();
    write_reg(REG_OFS_X, 17'($urandom_range(0, 400)) - 17'd200);
    write_reg(REG_OFS_Y, 17'($urandom_range(0, 400)) - 17'd200);
    write_reg(REG_OFS_Z, 17'($urandom_range(0, 400)) - 17'd200);
    write_reg(REG_THR, 17'($urandom_range(1500, 9000)));
    write_reg(REG_WIN, 17'($urandom_range(50, 2047)));
    write_reg(REG_GAP, 17'($urandom_range(0, 120)));
    write_reg(REG_LOCK, 17'($urandom_range(0, 1500)));
    write_reg(REG_ALPHA, 17'($urandom));
  endtask

  task automatic random_items(int count);
    int stop_at, k;
    stop_at = n_items + count;
    while (n_items < stop_at) begin
      k = $urandom_range(0, 99);
      if (k < 55) begin
        // tap sequence: 2..4 taps, spacing random around the window
        quiet($urandom_range(5, 50));
        repeat ($urandom_range(2, 4)) begin
          tap($urandom_range(0, 1) ? $urandom_range(40, 500) : $urandom_range(0, 1500));
          if ($urandom_range(0, 1)) quiet($urandom_range(1, 30));
        end
      end else if (k < 75) begin
        repeat ($urandom_range(1, 6)) quiet($urandom_range(1, 100));
      end else if (k < 85) begin
        repeat ($urandom_range(2, 5)) tap($urandom_range(0, 30));
      end else begin
        // noise: any field value, any time step
        sample_at($urandom, $urandom, $urandom, $urandom_range(0, 1) ? $urandom
                  : $urandom_range(0, 3000));
      end
    end
  endtask

  task automatic test_backpressure();
    drain();
    hold_ask++;                            // receiver holds off a long stretch
    gaps_on = 1'b0;
    repeat (8) quiet(10);
    tap(100); tap(100); tap(100);
    gaps_on = 1'b1;
    drain();                               // sender waits for every result
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_OFS_X;
    cfg_data = '0;
    hold_ask = 0;
    n_items = 0; n_results = 0; n_fail = 0; n_triples = 0; n_vib = 0; n_taps = 0;
    now_ms = 32'd1000;
    burst_left = 1;
    gaps_on = 1'b1;
    // reset defaults
    ofs_x = 0; ofs_y = 0; ofs_z = 0;
    thr_lsb = 6144; win_ms = 1000; gap_ms = 50; lock_ms = 1000; alpha_q16 = 6554;
    seeded = 0; base_fine = 64'd1 << 25; filt_fine = 64'd1 << 25;
    tap_cnt = 0; armed = 0; tap_seen = 0; det_seen = 0;
    win_start = 0; last_tap = 0; last_det = 0; rej_cnt = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_first_and_range();
    test_triple_tap();
    test_vibration();
    test_lockout();
    test_window_expired();
    test_time_wrap();
    test_register_extremes();
    test_backpressure();
    random_config();
    random_items(140);
    drain();
    write_reg(REG_THR, 17'd4096);
    write_reg(REG_GAP, 17'd50);
    write_reg(REG_LOCK, 17'd300);
    random_items(140);
    random_config();
    random_items(140);
    drain();

    $display("Covered %0d samples, %0d results: %0d taps, %0d triple taps, %0d vibration rejects,",
             n_items, n_results, n_taps, n_triples, n_vib);
    $display("register extremes, time wrap, lockout, window expiry and a long output hold.");
    if (n_fail == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (expected_q.size() != 0)
        $display("%0t ns: %0d expected results never arrived", $time, expected_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/att_pkg.sv
src/att_sqrt.sv
src/att_div100.sv
src/accel_triple_tap_detector_core.sv
tb/accel_triple_tap_detector_core_test.sv
